@@ sv/lpkt_pkg.sv @@
// ----------------------------------------------------------------------------
// lpkt_pkg
// Shared types and constants of the linear probing key table: field widths,
// operation and status codes, the controller states and the remainder unit
// step configuration.
// ----------------------------------------------------------------------------
package lpkt_pkg;

	// Field widths.
	localparam int KEY_W      = 32;
	localparam int TS_W       = 12;
	localparam int SLOT_IDX_W = 11;
	localparam int STATUS_W   = 2;

	// The all-ones key marks an empty slot and is never stored.
	localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

	// Reset value of the table size register.
	localparam logic [TS_W-1:0] TS_RESET = 12'd1033;

	// Operation codes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_CREATE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_INSERTED  = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_FULL      = 2'd3
	} lpkt_status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_PROBE,
		S_HOLD
	} lpkt_state_t;

	// Remainder unit: quotient bits retired per cycle and steps per key.
	localparam int UREM_BITS  = 4;
	localparam int UREM_STEPS = KEY_W / UREM_BITS;
	localparam int UREM_CNT_W = $clog2(UREM_STEPS);

endpackage

@@ sv/lpkt_if.sv @@
// ----------------------------------------------------------------------------
// lpkt_if
// Valid/ready channels of the key table: the request channel carries an
// operation and a key, the response channel carries a status and a slot.
// ----------------------------------------------------------------------------
interface lpkt_req_if;
	import lpkt_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface lpkt_rsp_if;
	import lpkt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_IDX_W-1:0] slot_index;

	modport source (output valid, output status, output slot_index, input ready);
	modport sink   (input valid, input status, input slot_index, output ready);
endinterface

@@ sv/lpkt_ram.sv @@
// ----------------------------------------------------------------------------
// lpkt_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lpkt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/lpkt_urem.sv @@
// ----------------------------------------------------------------------------
// lpkt_urem
// Multi-cycle unsigned remainder of a 32-bit key by the table size.
// Restoring division retires UREM_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module lpkt_urem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lpkt_pkg::KEY_W-1:0] dividend,
	input  logic [lpkt_pkg::TS_W-1:0]  divisor,
	output logic                     done,
	output logic [lpkt_pkg::TS_W-1:0]  rem
);
	import lpkt_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [UREM_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]      dvd_q;
	logic [TS_W-1:0]       div_q;
	logic [TS_W-1:0]       rem_q;
	logic [KEY_W-1:0]      dvd_nx;
	logic [TS_W-1:0]       rem_nx;

	// One step: shift in the next dividend bits, subtracting the divisor
	// whenever the partial remainder reaches it.
	always_comb begin
		logic [TS_W-1:0]  r;
		logic [KEY_W-1:0] d;
		logic [TS_W:0]    t;
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < UREM_BITS; i++) begin
			t = {r, d[KEY_W-1]};
			d = {d[KEY_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			r = t[TS_W-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == UREM_CNT_W'(UREM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

@@ sv/linear_probe_key_table_core.sv @@
// ----------------------------------------------------------------------------
// linear_probe_key_table_core
// Open-addressing key table with linear probing over a key store in RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the key store and marks every slot empty;
// during the sweep no request is taken (table size writes are). A request is
// then handled one at a time: it is taken, the remainder unit forms key mod
// size (four quotient bits per cycle), the first read is issued, and each
// slot examined is a read of the key store whose data returns in the next
// cycle. The result is then loaded into the output register once that
// register is free, and only after that is the next request taken. A
// reserved all-ones key skips the remainder unit and the probe. The result
// sits in an output register, so the next request is taken while it waits
// to be transferred.
module linear_probe_key_table_core #(
	parameter int CAPACITY = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [lpkt_pkg::TS_W-1:0]  cfg_wr_data,
	lpkt_req_if.sink                   req,
	lpkt_rsp_if.source                 rsp
);
	import lpkt_pkg::*;

	// Largest size in use, limited by the store and by the register width.
	localparam int SIZE_MAX = (CAPACITY < 4095) ? CAPACITY : 4095;
	localparam int SLOT_W   = $clog2(SIZE_MAX);
	localparam int ADDR_W   = $clog2(CAPACITY);

	lpkt_state_t           state_q, state_nx;
	logic [ADDR_W-1:0]     clr_q;
	logic [TS_W-1:0]       table_size_q;
	logic                  op_q;
	logic [KEY_W-1:0]      key_q;
	logic [TS_W-1:0]       size_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     cnt_q;
	lpkt_status_t          res_status_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  rsp_valid_q;
	lpkt_status_t          rsp_status_q;
	logic [SLOT_IDX_W-1:0] rsp_slot_q;

	logic [TS_W-1:0]       size_use;
	logic                  req_xfer;
	logic                  urem_start;
	logic                  urem_done;
	logic [TS_W-1:0]       urem_rem;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [KEY_W-1:0]      mem_wdata;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [KEY_W-1:0]      mem_rdata;
	logic                  clr_last;
	logic                  hit;
	logic                  empty;
	logic                  last;
	logic [TS_W:0]         slot_inc;
	logic [SLOT_W-1:0]     slot_next;
	logic                  rsp_load;
	logic [SLOT_W+SLOT_IDX_W-1:0] res_slot_ext;

	// Size in use: zero counts as one, and the store depth caps it.
	always_comb begin
		size_use = table_size_q;
		if (table_size_q == '0) begin
			size_use = TS_W'(1);
		end else if (table_size_q > TS_W'(SIZE_MAX)) begin
			size_use = TS_W'(SIZE_MAX);
		end
	end

	// Probe decisions on the slot whose data has just returned.
	assign hit       = (mem_rdata == key_q);
	assign empty     = (mem_rdata == EMPTY_KEY);
	assign last      = (TS_W'(cnt_q) == size_q - 1'b1);
	assign slot_inc  = (TS_W + 1)'(slot_q) + 1'b1;
	assign slot_next = (slot_inc >= {1'b0, size_q}) ? '0 : slot_inc[SLOT_W-1:0];
	assign clr_last  = (clr_q == ADDR_W'(CAPACITY - 1));
	assign req_xfer  = req.valid && req.ready;
	assign rsp_load  = (state_q == S_HOLD) && (!rsp_valid_q || rsp.ready);

	// Remainder unit for the start slot.
	lpkt_urem u_urem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (urem_start),
		.dividend (req.key),
		.divisor  (size_use),
		.done     (urem_done),
		.rem      (urem_rem)
	);

	// Key store.
	lpkt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_xfer) begin
					state_nx = (req.key == EMPTY_KEY) ? S_HOLD : S_DIV;
				end
			end
			S_DIV: begin
				if (urem_done) begin
					state_nx = S_PROBE;
				end
			end
			S_PROBE: begin
				if (hit || empty || last) begin
					state_nx = S_HOLD;
				end
			end
			S_HOLD: begin
				if (rsp_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Controller outputs: handshake, remainder start and store accesses.
	always_comb begin
		req.ready  = 1'b0;
		urem_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = ADDR_W'(slot_q);
		mem_wdata  = key_q;
		mem_re     = 1'b0;
		mem_raddr  = ADDR_W'(slot_next);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = EMPTY_KEY;
			end
			S_IDLE: begin
				req.ready  = 1'b1;
				urem_start = req.valid && (req.key != EMPTY_KEY);
			end
			S_DIV: begin
				mem_re    = urem_done;
				mem_raddr = ADDR_W'(urem_rem[SLOT_W-1:0]);
			end
			S_PROBE: begin
				mem_re = !hit && !empty && !last;
				mem_we = !hit && empty && (op_q == OP_CREATE);
			end
			S_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			table_size_q <= TS_RESET;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and probe payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					op_q         <= req.op;
					key_q        <= req.key;
					size_q       <= size_use;
					res_status_q <= STATUS_NOT_FOUND;
					res_slot_q   <= '0;
				end
			end
			S_DIV: begin
				if (urem_done) begin
					slot_q <= urem_rem[SLOT_W-1:0];
					cnt_q  <= '0;
				end
			end
			S_PROBE: begin
				if (hit) begin
					res_status_q <= STATUS_FOUND;
					res_slot_q   <= slot_q;
				end else if (empty) begin
					if (op_q == OP_CREATE) begin
						res_status_q <= STATUS_INSERTED;
						res_slot_q   <= slot_q;
					end else begin
						res_status_q <= STATUS_NOT_FOUND;
						res_slot_q   <= '0;
					end
				end else if (last) begin
					res_status_q <= (op_q == OP_CREATE) ? STATUS_FULL : STATUS_NOT_FOUND;
					res_slot_q   <= '0;
				end else begin
					slot_q <= slot_next;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	assign res_slot_ext = (SLOT_W + SLOT_IDX_W)'(res_slot_q);

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= res_slot_ext[SLOT_IDX_W-1:0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot_index = rsp_slot_q;

	// The reserved empty marker is only written by the clearing sweep.
	a_no_empty_insert: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && (state_q != S_CLEAR) |-> mem_wdata != EMPTY_KEY)
		else $error("empty marker written outside the clearing sweep");

	// A probe stays within the slots in use and within one pass.
	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> (TS_W'(cnt_q) < size_q) && (TS_W'(slot_q) < size_q))
		else $error("probe outside the table size in use");

	// An insert ends the probe.
	a_insert_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) && mem_we |=> state_q == S_HOLD)
		else $error("probe continued after an insert");

	// A new result appears only after a finished request.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_HOLD))
		else $error("result presented without a finished request");
endmodule

@@ tb/tb_linear_probe_key_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_linear_probe_key_table_core
// Self-checking bench for the linear probing key table. A short table of
// directed rows covers the reserved key, wrap-around, full and not-found
// results and the clamped table sizes. Random phases follow; each phase sets
// a new table size and sends lookups and creates with reused, colliding and
// random keys. Every response transfer is checked against a local model of
// the key store. Both sides idle at random, and the response side also holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_linear_probe_key_table_core;
	import lpkt_pkg::*;

	localparam int          TABLE_CAPACITY = 2048;
	localparam int          RANDOM_ITEMS   = 1900;
	localparam int          IDLE_PCT       = 21;
	localparam int          HOLD_AT        = 300;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          BURST_START    = 900;
	localparam int          BURST_END      = 1250;
	localparam int          KEY_POOL_MAX   = 256;
	localparam int          MAX_REPORTS    = 10;
	localparam int          TAIL_CYCLES    = TABLE_CAPACITY + 32;
	// Every request walking a whole table, with room for stalls and gaps.
	localparam int unsigned CYCLE_LIMIT    =
		4 * ((RANDOM_ITEMS + 32) * (TABLE_CAPACITY + 96) + 4 * TABLE_CAPACITY);

	typedef enum logic {
		ROW_CFG,
		ROW_REQ
	} row_kind_t;

	typedef struct packed {
		lpkt_status_t          status;
		logic [SLOT_IDX_W-1:0] slot;
	} table_result_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		logic [KEY_W-1:0] value;
		logic             typed;
		table_result_t    result;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [TS_W-1:0]       cfg_wr_data;

	lpkt_req_if req_ch ();
	lpkt_rsp_if rsp_ch ();

	// Local copy of the key store and of the table size register.
	logic [KEY_W-1:0]      key_mirror [TABLE_CAPACITY];
	logic [TS_W-1:0]       size_mirror;

	table_result_t         pending_results [$];
	stim_row_t             directed_rows [$];
	logic [KEY_W-1:0]      known_keys [$];
	int unsigned           mismatch_count;

	// Flags shared between the request and response processes.
	logic                  burst_mode;
	logic                  hold_req;
	logic                  hold_active;

	linear_probe_key_table_core #(
		.CAPACITY (TABLE_CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run the probe on the local store and apply an insert where one happens.
	function automatic table_result_t probe_key_table(input logic op,
			input logic [KEY_W-1:0] key);
		table_result_t res;
		int unsigned   span;
		int unsigned   slot;
		int unsigned   step;
		logic          done;
		begin
			span = 32'(size_mirror);
			if (span == 0)
				span = 1;
			if (span > TABLE_CAPACITY)
				span = TABLE_CAPACITY;
			res.status = (op == OP_CREATE) ? STATUS_FULL : STATUS_NOT_FOUND;
			res.slot   = '0;
			done       = 1'b0;
			if (key == EMPTY_KEY) begin
				res.status = STATUS_NOT_FOUND;
			end else begin
				slot = key % span;
				for (step = 0; step < span && !done; step++) begin
					if (key_mirror[slot] == key) begin
						res.status = STATUS_FOUND;
						res.slot   = slot[SLOT_IDX_W-1:0];
						done       = 1'b1;
					end else if (key_mirror[slot] == EMPTY_KEY) begin
						if (op == OP_CREATE) begin
							key_mirror[slot] = key;
							res.status       = STATUS_INSERTED;
							res.slot         = slot[SLOT_IDX_W-1:0];
						end else begin
							res.status = STATUS_NOT_FOUND;
						end
						done = 1'b1;
					end else begin
						slot = (slot + 1 >= span) ? 0 : slot + 1;
					end
				end
			end
			return res;
		end
	endfunction

	task automatic add_row(input row_kind_t kind, input logic op,
			input logic [KEY_W-1:0] value, input logic typed,
			input lpkt_status_t status, input int unsigned slot);
		stim_row_t row;
		begin
			row.kind          = kind;
			row.op            = op;
			row.value         = value;
			row.typed         = typed;
			row.result.status = status;
			row.result.slot   = slot[SLOT_IDX_W-1:0];
			directed_rows     = {directed_rows, row};
		end
	endtask

	// Offer one request, starting and ending at a falling edge. The valid is
	// left high so that a following request can go out without a gap.
	task automatic offer_request(input logic op, input logic [KEY_W-1:0] key,
			input logic typed, input table_result_t typed_res);
		table_result_t predicted;
		begin
			while (!burst_mode && !hold_active && $urandom_range(99) < IDLE_PCT) begin
				req_ch.valid = 1'b0;
				@(negedge clk);
			end
			req_ch.valid = 1'b1;
			req_ch.op    = op;
			req_ch.key   = key;
			@(posedge clk);
			while (!req_ch.ready)
				@(posedge clk);
			predicted       = probe_key_table(op, key);
			pending_results = {pending_results, typed ? typed_res : predicted};
			@(negedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has come back.
	task automatic wait_results_drained();
		begin
			req_ch.valid = 1'b0;
			while (pending_results.size() != 0)
				@(negedge clk);
		end
	endtask

	task automatic write_table_size(input logic [TS_W-1:0] value);
		begin
			cfg_wr_en   = 1'b1;
			cfg_wr_data = value;
			@(negedge clk);
			cfg_wr_en   = 1'b0;
			size_mirror = value;
		end
	endtask

	// Response side: random idling, one long hold-off on request.
	initial begin
		rsp_ch.ready = 1'b0;
		hold_active  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 1'b0;
				hold_active  = 1'b1;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_active  = 1'b0;
			end
			rsp_ch.ready = burst_mode || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each response transfer with the oldest expectation.
	always @(posedge clk) begin : check_response
		table_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: status %0d slot %0d",
						rsp_ch.status, rsp_ch.slot_index);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.slot_index !== want.slot) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: want status %0d slot %0d, got %0d slot %0d",
							want.status, want.slot, rsp_ch.status, rsp_ch.slot_index);
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (CYCLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reset, directed rows, random phases, then the final verdict.
	initial begin : stimulus
		int unsigned      idx;
		int unsigned      random_sent;
		int unsigned      phase_len;
		int unsigned      span;
		int unsigned      pick;
		int unsigned      j;
		logic [TS_W-1:0]  size_pick;
		logic             op;
		logic [KEY_W-1:0] key;
		table_result_t    no_result;

		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_LOOKUP;
		req_ch.key      = '0;
		burst_mode      = 1'b0;
		hold_req        = 1'b0;
		mismatch_count  = 0;
		size_mirror     = TS_RESET;
		no_result       = '0;
		random_sent     = 0;
		for (idx = 0; idx < TABLE_CAPACITY; idx++)
			key_mirror[idx] = EMPTY_KEY;

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, first at the reset table size of 1033.
		add_row(ROW_REQ, OP_LOOKUP, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 0);
		add_row(ROW_REQ, OP_LOOKUP, EMPTY_KEY,     1'b1, STATUS_NOT_FOUND, 0);
		add_row(ROW_REQ, OP_CREATE, EMPTY_KEY,     1'b1, STATUS_NOT_FOUND, 0);
		add_row(ROW_REQ, OP_CREATE, 32'h0000_0000, 1'b1, STATUS_INSERTED,  0);
		add_row(ROW_REQ, OP_CREATE, 32'h0000_0000, 1'b1, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_LOOKUP, 32'h0000_0000, 1'b1, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'd1033,      1'b1, STATUS_INSERTED,  1);
		add_row(ROW_REQ, OP_CREATE, 32'd1032,      1'b1, STATUS_INSERTED,  1032);
		// Collides at the last slot and wraps past the front of the table.
		add_row(ROW_REQ, OP_CREATE, 32'd2065,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd2065,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd3099,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'hFFFF_FFFE, 1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'h8000_0000, 1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'h5555_5555, 1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'hAAAA_AAAA, 1'b0, STATUS_FOUND,     0);
		// A size of zero acts as one slot, which already holds key zero.
		add_row(ROW_CFG, OP_LOOKUP, 32'd0,         1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'd5,         1'b1, STATUS_FULL,      0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd5,         1'b1, STATUS_NOT_FOUND, 0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd0,         1'b1, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_LOOKUP, EMPTY_KEY,     1'b1, STATUS_NOT_FOUND, 0);
		// Three slots, all taken: full pass for both operations.
		add_row(ROW_CFG, OP_LOOKUP, 32'd3,         1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'd7,         1'b1, STATUS_FULL,      0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd7,         1'b1, STATUS_NOT_FOUND, 0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd2065,      1'b0, STATUS_FOUND,     0);
		// An oversized value is clamped to the full capacity.
		add_row(ROW_CFG, OP_LOOKUP, 32'd4095,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_CREATE, 32'd2047,      1'b1, STATUS_INSERTED,  2047);
		add_row(ROW_REQ, OP_LOOKUP, 32'd4095,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_CFG, OP_LOOKUP, 32'd2048,      1'b0, STATUS_FOUND,     0);
		add_row(ROW_REQ, OP_LOOKUP, 32'd2047,      1'b1, STATUS_FOUND,     2047);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_results_drained();
				write_table_size(directed_rows[i].value[TS_W-1:0]);
			end else begin
				offer_request(directed_rows[i].op, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].result);
			end
		end

		// Random phases, each under a fresh table size.
		while (random_sent < RANDOM_ITEMS) begin
			wait_results_drained();
			pick = $urandom_range(99);
			if (pick < 45) begin
				size_pick = TS_W'($urandom_range(1, 24));
			end else if (pick < 65) begin
				size_pick = TS_W'($urandom_range(25, 200));
			end else if (pick < 80) begin
				case ($urandom_range(5))
					0: size_pick = 12'd67;
					1: size_pick = 12'd131;
					2: size_pick = 12'd257;
					3: size_pick = 12'd521;
					4: size_pick = 12'd1031;
					default: size_pick = 12'd1033;
				endcase
			end else if (pick < 88) begin
				size_pick = TS_W'($urandom_range(201, 2047));
			end else if (pick < 93) begin
				size_pick = 12'd2048;
			end else if (pick < 96) begin
				size_pick = 12'd0;
			end else begin
				size_pick = TS_W'($urandom_range(2049, 4095));
			end
			write_table_size(size_pick);
			span = 32'(size_pick);
			if (span == 0)
				span = 1;
			if (span > TABLE_CAPACITY)
				span = TABLE_CAPACITY;

			phase_len = $urandom_range(40, 160);
			for (j = 0; j < phase_len && random_sent < RANDOM_ITEMS; j++) begin
				if (random_sent == HOLD_AT)
					hold_req = 1'b1;
				burst_mode = (random_sent >= BURST_START && random_sent < BURST_END);

				// Mostly keys that meet stored ones, plus noise and the reserved key.
				pick = $urandom_range(99);
				if (pick < 35 && known_keys.size() != 0)
					key = known_keys[$urandom_range(known_keys.size() - 1)];
				else if (pick < 60)
					key = $urandom_range(span - 1) + span * $urandom_range(4000);
				else if (pick < 95)
					key = $urandom;
				else if (pick < 97)
					key = EMPTY_KEY;
				else
					key = EMPTY_KEY - $urandom_range(1, 64);
				op = ($urandom_range(99) < 60) ? OP_CREATE : OP_LOOKUP;

				if (op == OP_CREATE && key != EMPTY_KEY) begin
					known_keys = {known_keys, key};
					if (known_keys.size() > KEY_POOL_MAX)
						void'(known_keys.pop_front());
				end
				offer_request(op, key, 1'b0, no_result);
				random_sent++;
			end
		end
		burst_mode = 1'b0;

		// Let any stray result show up before the verdict.
		wait_results_drained();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lpkt_pkg.sv
sv/lpkt_if.sv
sv/lpkt_ram.sv
sv/lpkt_urem.sv
sv/linear_probe_key_table_core.sv
tb/tb_linear_probe_key_table_core.sv
